// File: sv/abs_warning_qualifier_assert.svh
// Assertion macros used by the ABS warning qualifier core.
`ifndef ABS_WARNING_QUALIFIER_ASSERT_SVH
`define ABS_WARNING_QUALIFIER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AWQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("abs warning qualifier: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AWQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("abs warning qualifier: next-cycle check failed");

`endif

// File: sv/abs_wq_pkg.sv
// Types and constants shared by the ABS warning qualifier modules.
`timescale 1ns / 1ps
package abs_wq_pkg;

	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 8;
	localparam int ITEM_W      = 43;
	localparam int RES_W       = 3;

	localparam logic [8:0]  SPEED_THR_RST = 9'd30;
	localparam logic [7:0]  DECEL_THR_RST = 8'd8;
	localparam logic [15:0] WINDOW_RST    = 16'd100;
	localparam logic [15:0] ENGAGE_RST    = 16'd150;
	localparam logic [15:0] RELEASE_RST   = 16'd200;
	localparam logic [15:0] BLINK_RST     = 16'd180;

	// Milliseconds per second, used to scale the speed drop.
	localparam logic [9:0] MS_PER_S = 10'd1000;

	typedef enum logic [2:0] {
		REG_SPEED_THR,
		REG_DECEL_THR,
		REG_WINDOW,
		REG_ENGAGE,
		REG_RELEASE,
		REG_BLINK
	} reg_idx_t;

	typedef struct packed {
		logic [8:0]  speed_thr;
		logic [7:0]  decel_thr;
		logic [15:0] window;
		logic [15:0] engage;
		logic [15:0] release_hold;
		logic [15:0] blink_half;
	} cfg_t;

	// First declared member sits in the highest bits.
	typedef struct packed {
		logic        brake_pressed;
		logic        abs_request;
		logic [8:0]  veh_speed;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic hard_braking;
		logic lamp_on;
		logic abs_engaged;
	} result_t;

endpackage

// File: sv/abs_warning_qualifier.sv
// Top level of the ABS warning qualifier: stream stages and register port.
//
//  Channel   Dir  Width  Contents
//  s_*       in   48     one timed sample per beat
//  m_*       out  8      one qualified result per beat
//  APB       in   32     six setting registers at byte offsets 0x00..0x14
//
// One beat in, one beat out; a sample may enter every cycle while the result is not stalled.
// Registers on the path: input register, then result register.
// The sample state is updated in the cycle the result register loads.
// A stalled result holds; one further sample waits in the input register.
// Reset restores the register defaults, clears the valid flags and clears all sample state in the core.
`timescale 1ns / 1ps
module abs_warning_qualifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] now_ms, [40:32] veh_speed, [41] abs_request, [42] brake_pressed, rest zero
	input  logic [abs_wq_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] abs_engaged, [1] lamp_on, [2] hard_braking, rest zero
	output logic [abs_wq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [abs_wq_pkg::PADDR_W-1:0]     paddr,
	input  logic [abs_wq_pkg::PDATA_W-1:0]     pwdata,
	output logic [abs_wq_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import abs_wq_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    take;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_t'(s_tdata[ITEM_W-1:0]);
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_s2};

	abs_wq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abs_wq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

endmodule

// File: sv/abs_wq_cfg.sv
// APB register file holding the thresholds and timing settings.
`timescale 1ns / 1ps
module abs_wq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [abs_wq_pkg::PADDR_W-1:0] paddr,
	input  logic [abs_wq_pkg::PDATA_W-1:0] pwdata,
	output logic [abs_wq_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output abs_wq_pkg::cfg_t              cfg
);
	import abs_wq_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_thr    <= SPEED_THR_RST;
			cfg_q.decel_thr    <= DECEL_THR_RST;
			cfg_q.window       <= WINDOW_RST;
			cfg_q.engage       <= ENGAGE_RST;
			cfg_q.release_hold <= RELEASE_RST;
			cfg_q.blink_half   <= BLINK_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SPEED_THR: cfg_q.speed_thr    <= pwdata[8:0];
				REG_DECEL_THR: cfg_q.decel_thr    <= pwdata[7:0];
				REG_WINDOW:    cfg_q.window       <= pwdata[15:0];
				REG_ENGAGE:    cfg_q.engage       <= pwdata[15:0];
				REG_RELEASE:   cfg_q.release_hold <= pwdata[15:0];
				REG_BLINK:     cfg_q.blink_half   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SPEED_THR: prdata = PDATA_W'(cfg_q.speed_thr);
			REG_DECEL_THR: prdata = PDATA_W'(cfg_q.decel_thr);
			REG_WINDOW:    prdata = PDATA_W'(cfg_q.window);
			REG_ENGAGE:    prdata = PDATA_W'(cfg_q.engage);
			REG_RELEASE:   prdata = PDATA_W'(cfg_q.release_hold);
			REG_BLINK:     prdata = PDATA_W'(cfg_q.blink_half);
			default:       prdata = '0;
		endcase
	end

endmodule

// File: sv/abs_wq_core.sv
// Deceleration test, ABS engage/release logic and lamp blink state.
`timescale 1ns / 1ps
`include "abs_warning_qualifier_assert.svh"
module abs_wq_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  abs_wq_pkg::item_t    item,
	input  abs_wq_pkg::cfg_t     cfg,
	output abs_wq_pkg::result_t  res
);
	import abs_wq_pkg::*;

	logic [8:0]  last_speed_q;
	logic [31:0] last_time_q;
	logic        decel_q;
	logic [31:0] req_start_q;
	logic [31:0] act_start_q;
	logic [31:0] blink_mark_q;
	logic        active_q;
	logic        blink_q;

	logic        unset;
	logic [31:0] dt;
	logic        upd;
	logic        record;
	logic [8:0]  drop;
	logic [18:0] drop_scaled;
	logic [39:0] limit;
	logic        decel_d;
	logic        fire;
	logic [31:0] req_start_d;
	logic [31:0] act_start_d;
	logic [31:0] blink_mark_d;
	logic        active_mid;
	logic        active_d;
	logic        blink_mid;
	logic        blink_d;

	// A drop only counts when the speed did not rise; a rise never sets the flag.
	assign unset       = (last_time_q == 32'd0);
	assign dt          = item.now_ms - last_time_q;
	assign upd         = !unset && (dt >= 32'(cfg.window));
	assign record      = unset || upd;
	assign drop        = last_speed_q - item.veh_speed;
	assign drop_scaled = 19'(drop) * 19'(MS_PER_S);
	assign limit       = 40'(cfg.decel_thr) * 40'(dt);
	assign decel_d     = upd ? ((last_speed_q >= item.veh_speed) &&
		(40'(drop_scaled) > limit)) : decel_q;

	assign fire = item.abs_request && item.brake_pressed &&
		(item.veh_speed > cfg.speed_thr) && decel_d;

	always_comb begin
		req_start_d  = 32'd0;
		act_start_d  = act_start_q;
		active_mid   = active_q;
		blink_mid    = blink_q;
		blink_mark_d = blink_mark_q;
		blink_d      = blink_q;
		if (fire) begin
			// A start time of zero reads as unset, so it is taken again here.
			req_start_d = (req_start_q == 32'd0) ? item.now_ms : req_start_q;
			if (!active_q && ((item.now_ms - req_start_d) > 32'(cfg.engage))) begin
				active_mid  = 1'b1;
				act_start_d = item.now_ms;
			end
		end else if (active_q && ((item.now_ms - act_start_q) > 32'(cfg.release_hold))) begin
			active_mid = 1'b0;
			blink_mid  = 1'b0;
		end
		active_d = active_mid;
		blink_d  = blink_mid;
		if (active_mid && ((item.now_ms - blink_mark_q) > 32'(cfg.blink_half))) begin
			blink_mark_d = item.now_ms;
			blink_d      = !blink_mid;
		end
	end

	assign res.abs_engaged  = active_d;
	assign res.lamp_on      = active_d && blink_d;
	assign res.hard_braking = decel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
			last_time_q  <= '0;
			decel_q      <= 1'b0;
			req_start_q  <= '0;
			act_start_q  <= '0;
			blink_mark_q <= '0;
			active_q     <= 1'b0;
			blink_q      <= 1'b0;
		end else if (step) begin
			if (record) begin
				last_speed_q <= item.veh_speed;
				last_time_q  <= item.now_ms;
			end
			decel_q      <= decel_d;
			req_start_q  <= req_start_d;
			act_start_q  <= act_start_d;
			blink_mark_q <= blink_mark_d;
			active_q     <= active_d;
			blink_q      <= blink_d;
		end
	end

	`AWQ_ASSERT_IMP(a_blink_needs_active, clk, arst_n, !active_q, !blink_q)
	`AWQ_ASSERT_NXT(a_req_cleared, clk, arst_n, step && !fire, req_start_q == 32'd0)
	`AWQ_ASSERT_NXT(a_first_sample, clk, arst_n, step && unset,
		last_time_q == $past(item.now_ms) && last_speed_q == $past(item.veh_speed))
	`AWQ_ASSERT_NXT(a_hold_idle, clk, arst_n, !step,
		$stable(active_q) && $stable(blink_q) && $stable(decel_q) && $stable(last_time_q))

endmodule
